// ===== design/dual_inverter_enable_sequencer_top_defines.svh =====
// Assertion macros shared by the sequencer RTL.
// Each macro expands to one labeled concurrent assertion that is checked on the
// rising clock edge and is switched off while reset is high.
`ifndef DUAL_INVERTER_ENABLE_SEQUENCER_TOP_DEFINES_SVH
`define DUAL_INVERTER_ENABLE_SEQUENCER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DIES_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DIES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dies_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dies_pkg;

   // Field widths.
   localparam int unsigned ID_W     = 11;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned SCALE_W  = 10;
   localparam int unsigned TORQUE_W = 10;
   localparam int unsigned CS_W     = 3;
   localparam int unsigned PROD_W   = SAMPLE_W + SCALE_W;

   // Configuration port geometry.
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 5;

   // Full-scale pedal reading; the setpoint is product / SAMPLE_FULL.
   localparam int unsigned SAMPLE_FULL = 4095;

   // Reset values of the configuration registers.
   localparam logic [ID_W-1:0]    RST_RIGHT_STATUS_ID  = 11'd645;
   localparam logic [ID_W-1:0]    RST_LEFT_STATUS_ID   = 11'd644;
   localparam logic [ID_W-1:0]    RST_RIGHT_COMMAND_ID = 11'd390;
   localparam logic [ID_W-1:0]    RST_LEFT_COMMAND_ID  = 11'd389;
   localparam logic [BYTE_W-1:0]  RST_TORQUE_LIMIT    = 8'd50;
   localparam logic [SCALE_W-1:0] RST_FULL_SCALE      = 10'd500;

   // Status codes reported by an inverter.
   localparam logic [BYTE_W-1:0] REPORT_READY       = 8'h01;
   localparam logic [BYTE_W-1:0] REPORT_DC_ON       = 8'h11;
   localparam logic [BYTE_W-1:0] REPORT_QUIT_DC_ON  = 8'h19;
   localparam logic [BYTE_W-1:0] REPORT_INV_ON      = 8'h59;
   localparam logic [BYTE_W-1:0] REPORT_RUNNING     = 8'h79;

   // Control bytes sent to an inverter.
   localparam logic [BYTE_W-1:0] CTL_NONE        = 8'h00;
   localparam logic [BYTE_W-1:0] CTL_DC_ON       = 8'h02;
   localparam logic [BYTE_W-1:0] CTL_ENABLE      = 8'h07;
   localparam logic [BYTE_W-1:0] CTL_ERROR_RESET = 8'h08;

   typedef enum logic [2:0] {
      INV_UNKNOWN    = 3'd0,
      INV_READY      = 3'd1,
      INV_DC_ON      = 3'd2,
      INV_QUIT_DC_ON = 3'd3,
      INV_ON         = 3'd4,
      INV_RUNNING    = 3'd5,
      INV_DERATING   = 3'd6,
      INV_ERROR      = 3'd7
   } inv_state_type;

   typedef enum logic [CS_W-1:0] {
      CS_UNKNOWN     = 3'd0,
      CS_DC_ON       = 3'd1,
      CS_ENABLE      = 3'd2,
      CS_INV_ON      = 3'd3,
      CS_READY       = 3'd4,
      CS_RESET_RIGHT = 3'd5,
      CS_RESET_LEFT  = 3'd6,
      CS_RUNNING     = 3'd7
   } control_state_type;

   typedef enum logic [2:0] {
      REG_RIGHT_STATUS_ID  = 3'd0,
      REG_LEFT_STATUS_ID   = 3'd1,
      REG_RIGHT_COMMAND_ID = 3'd2,
      REG_LEFT_COMMAND_ID  = 3'd3,
      REG_TORQUE_LIMIT     = 3'd4,
      REG_FULL_SCALE       = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [ID_W-1:0]    right_status_id;
      logic [ID_W-1:0]    left_status_id;
      logic [ID_W-1:0]    right_command_id;
      logic [ID_W-1:0]    left_command_id;
      logic [BYTE_W-1:0]  torque_limit;
      logic [SCALE_W-1:0] throttle_full_scale;
   } cfg_type;

   // Error bit wins over derating, then exact codes; anything else is unknown.
   function automatic inv_state_type decode_status(input logic [BYTE_W-1:0] status);
      inv_state_type st;
      if (status[1]) begin
         st = INV_ERROR;
      end else if (status[7]) begin
         st = INV_DERATING;
      end else begin
         case (status)
            REPORT_READY:      st = INV_READY;
            REPORT_DC_ON:      st = INV_DC_ON;
            REPORT_QUIT_DC_ON: st = INV_QUIT_DC_ON;
            REPORT_INV_ON:     st = INV_ON;
            REPORT_RUNNING:    st = INV_RUNNING;
            default:           st = INV_UNKNOWN;
         endcase
      end
      return st;
   endfunction

endpackage

`default_nettype wire

// ===== design/dies_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dies_csr
   import dies_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     psel,
   input  wire                     penable,
   input  wire                     pwrite,
   input  wire  [CSR_ADDR_W-1:0]   paddr,
   input  wire  [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   // Registers sit on word addresses; the two low address bits are ignored.
   assign index    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_RIGHT_STATUS_ID:  cfg_in.right_status_id  = pwdata[ID_W-1:0];
            REG_LEFT_STATUS_ID:   cfg_in.left_status_id   = pwdata[ID_W-1:0];
            REG_RIGHT_COMMAND_ID: cfg_in.right_command_id = pwdata[ID_W-1:0];
            REG_LEFT_COMMAND_ID:  cfg_in.left_command_id  = pwdata[ID_W-1:0];
            REG_TORQUE_LIMIT:     cfg_in.torque_limit     = pwdata[BYTE_W-1:0];
            REG_FULL_SCALE:       cfg_in.throttle_full_scale = pwdata[SCALE_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_RIGHT_STATUS_ID:  prdata = CSR_DATA_W'(cfg_ff.right_status_id);
         REG_LEFT_STATUS_ID:   prdata = CSR_DATA_W'(cfg_ff.left_status_id);
         REG_RIGHT_COMMAND_ID: prdata = CSR_DATA_W'(cfg_ff.right_command_id);
         REG_LEFT_COMMAND_ID:  prdata = CSR_DATA_W'(cfg_ff.left_command_id);
         REG_TORQUE_LIMIT:     prdata = CSR_DATA_W'(cfg_ff.torque_limit);
         REG_FULL_SCALE:       prdata = CSR_DATA_W'(cfg_ff.throttle_full_scale);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.right_status_id     <= RST_RIGHT_STATUS_ID;
         cfg_ff.left_status_id      <= RST_LEFT_STATUS_ID;
         cfg_ff.right_command_id    <= RST_RIGHT_COMMAND_ID;
         cfg_ff.left_command_id     <= RST_LEFT_COMMAND_ID;
         cfg_ff.torque_limit        <= RST_TORQUE_LIMIT;
         cfg_ff.throttle_full_scale <= RST_FULL_SCALE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/dual_inverter_enable_sequencer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "dual_inverter_enable_sequencer_top_defines.svh"

// Channel   Direction  Handshake             Word
// req_      in         req_valid/req_stall   status frame or control tick
// rsp_      out        rsp_valid/rsp_stall   one command frame (right, then left)
// APB       in/out     psel/penable/pready   configuration registers
//
// A status frame produces no word. A control tick holds the decision stage while
// it feeds the single output register first the right and then the left command
// frame. The right word reaches rsp_ through stage 1, the decision stage and the
// output register, and the left word follows once the right word is taken.
// Reset is synchronous and resets the control state and CSRs, not the payload.
// A stall on rsp_ holds the output register and backs up into req_stall in the
// same cycle; status frames keep flowing while a tick waits in the decision stage.

module dual_inverter_enable_sequencer_top
   import dies_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,

   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire                   req_action,
   input  wire  [ID_W-1:0]       req_frame_id,
   input  wire  [BYTE_W-1:0]     req_status_byte,
   input  wire  [SAMPLE_W-1:0]   req_throttle_sample,
   input  wire                   req_start_button_n,

   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [ID_W-1:0]       rsp_command_id,
   output logic [BYTE_W-1:0]     rsp_control_byte,
   output logic [TORQUE_W-1:0]   rsp_torque_setpoint,
   output logic [BYTE_W-1:0]     rsp_limit_byte,
   output logic [CS_W-1:0]       rsp_control_state,
   output logic                  rsp_brake_light,
   output logic                  rsp_last_frame,

   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire  [CSR_ADDR_W-1:0] paddr,
   input  wire  [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;

   // The register file is its own unit; the sequencer only reads its fields.
   dies_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Stage 1 holds the accepted word.
   logic                s1_valid_ff;
   logic                s1_action_ff;
   logic [ID_W-1:0]     s1_frame_id_ff;
   logic [BYTE_W-1:0]   s1_status_byte_ff;
   logic [SAMPLE_W-1:0] s1_throttle_sample_ff;
   logic                s1_start_button_n_ff;

   // Architectural state of the sequencer.
   inv_state_type       right_state_ff, right_state_in;
   inv_state_type       left_state_ff, left_state_in;
   logic [BYTE_W-1:0]   last_status_ff, last_status_in;
   logic                drive_ready_ff, drive_ready_in;
   logic                brake_on_ff, brake_on_in;

   // Stage 2 holds the decision for one tick until both frames have left.
   logic                s2_valid_ff;
   logic                s2_left_ff;
   logic [BYTE_W-1:0]   s2_ctl_right_ff;
   logic [BYTE_W-1:0]   s2_ctl_left_ff;
   control_state_type   s2_cs_ff;
   logic                s2_brake_ff;
   logic                s2_torque_en_ff;
   logic [PROD_W-1:0]   s2_product_ff;

   // Decision made from stage 1.
   logic [BYTE_W-1:0]   ctl_right;
   logic [BYTE_W-1:0]   ctl_left;
   control_state_type   cs;
   logic                both_running;
   logic                torque_en;
   logic [PROD_W-1:0]   product;

   // Handshake controls.
   logic                out_load;
   logic                s2_free;
   logic                s1_advance;
   logic                s1_fire;
   logic                s2_take;

   // Divide by full scale: reciprocal estimate plus one correction step.
   logic [PROD_W:0]     est_sum;
   logic [ID_W-1:0]     quot_est;
   logic [PROD_W:0]     rem_full;
   logic [ID_W-1:0]     quot;
   logic [TORQUE_W-1:0] torque;

   // The output register frees up when it is empty or its word is taken.
   // Stage 2 frees up once its left frame moves into the output register.
   // Status frames never wait on stage 2; a tick needs it free.
   assign out_load   = !rsp_valid || !rsp_stall;
   assign s2_free    = !s2_valid_ff || (s2_left_ff && out_load);
   assign s1_advance = !s1_action_ff || s2_free;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign s2_take    = s1_fire && s1_action_ff;
   assign req_stall  = s1_valid_ff && !s1_advance;

   // State update for the word leaving stage 1.
   always_comb begin
      right_state_in = right_state_ff;
      left_state_in  = left_state_ff;
      last_status_in = last_status_ff;
      drive_ready_in = drive_ready_ff;
      brake_on_in    = brake_on_ff;
      if (s1_fire) begin
         if (!s1_action_ff) begin
            // The right id wins when both ids are programmed the same.
            if (s1_frame_id_ff == cfg.right_status_id) begin
               right_state_in = decode_status(s1_status_byte_ff);
               last_status_in = s1_status_byte_ff;
            end else if (s1_frame_id_ff == cfg.left_status_id) begin
               left_state_in  = decode_status(s1_status_byte_ff);
               last_status_in = s1_status_byte_ff;
            end
         end else begin
            drive_ready_in = drive_ready_ff || !s1_start_button_n_ff;
            brake_on_in    = brake_on_ff || both_running;
         end
      end
   end

   // Priority chain over the two inverter states at the time of the tick.
   always_comb begin
      both_running = (right_state_ff == INV_RUNNING) && (left_state_ff == INV_RUNNING);
      ctl_right    = CTL_NONE;
      ctl_left     = CTL_NONE;
      cs           = CS_UNKNOWN;
      torque_en    = 1'b0;
      if ((right_state_ff == INV_READY) && (left_state_ff == INV_READY)) begin
         ctl_right = CTL_DC_ON;
         ctl_left  = CTL_DC_ON;
         cs        = CS_DC_ON;
      end else if ((right_state_ff == INV_QUIT_DC_ON) &&
                   (left_state_ff == INV_QUIT_DC_ON)) begin
         ctl_right = CTL_ENABLE;
         ctl_left  = CTL_ENABLE;
         cs        = CS_ENABLE;
      end else if ((right_state_ff == INV_ON) && (left_state_ff == INV_ON)) begin
         ctl_right = CTL_ENABLE;
         ctl_left  = CTL_ENABLE;
         cs        = CS_INV_ON;
      end else if (both_running) begin
         ctl_right = CTL_ENABLE;
         ctl_left  = CTL_ENABLE;
         // The drive-ready latch includes a press on this very tick.
         if (drive_ready_in) begin
            cs        = CS_RUNNING;
            torque_en = (last_status_ff == REPORT_RUNNING);
         end else begin
            cs = CS_READY;
         end
      end else if (right_state_ff == INV_ERROR) begin
         ctl_right = CTL_ERROR_RESET;
         cs        = CS_RESET_RIGHT;
      end else if (left_state_ff == INV_ERROR) begin
         ctl_left = CTL_ERROR_RESET;
         cs       = CS_RESET_LEFT;
      end
   end

   assign product = PROD_W'(s1_throttle_sample_ff) * PROD_W'(cfg.throttle_full_scale);

   // floor(p / 4095) with p below 2^22: the estimate (p + p/4096) / 4096 is never
   // high and at most one low, so a single compare and increment finishes it.
   assign est_sum  = {1'b0, s2_product_ff} + (PROD_W+1)'(s2_product_ff >> SAMPLE_W);
   assign quot_est = est_sum[PROD_W:SAMPLE_W];
   assign rem_full = {1'b0, s2_product_ff} + (PROD_W+1)'(quot_est)
                     - {quot_est, {SAMPLE_W{1'b0}}};
   assign quot     = quot_est + ID_W'(rem_full >= (PROD_W+1)'(SAMPLE_FULL));
   assign torque   = s2_torque_en_ff ? quot[TORQUE_W-1:0] : '0;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s2_left_ff     <= 1'b0;
         rsp_valid      <= 1'b0;
         right_state_ff <= INV_UNKNOWN;
         left_state_ff  <= INV_UNKNOWN;
         last_status_ff <= '0;
         drive_ready_ff <= 1'b0;
         brake_on_ff    <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_take) begin
            s2_valid_ff <= 1'b1;
            s2_left_ff  <= 1'b0;
         end else if (s2_valid_ff && out_load) begin
            s2_valid_ff <= !s2_left_ff;
            s2_left_ff  <= 1'b1;
         end
         if (out_load) begin
            rsp_valid <= s2_valid_ff;
         end
         right_state_ff <= right_state_in;
         left_state_ff  <= left_state_in;
         last_status_ff <= last_status_in;
         drive_ready_ff <= drive_ready_in;
         brake_on_ff    <= brake_on_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_action_ff          <= req_action;
         s1_frame_id_ff        <= req_frame_id;
         s1_status_byte_ff     <= req_status_byte;
         s1_throttle_sample_ff <= req_throttle_sample;
         s1_start_button_n_ff  <= req_start_button_n;
      end
      if (s2_take) begin
         s2_ctl_right_ff <= ctl_right;
         s2_ctl_left_ff  <= ctl_left;
         s2_cs_ff        <= cs;
         s2_brake_ff     <= brake_on_in;
         s2_torque_en_ff <= torque_en;
         s2_product_ff   <= product;
      end
      if (out_load && s2_valid_ff) begin
         rsp_command_id      <= s2_left_ff ? cfg.left_command_id : cfg.right_command_id;
         rsp_control_byte    <= s2_left_ff ? s2_ctl_left_ff : s2_ctl_right_ff;
         rsp_torque_setpoint <= torque;
         rsp_limit_byte      <= s2_torque_en_ff ? cfg.torque_limit : '0;
         rsp_control_state   <= s2_cs_ff;
         rsp_brake_light     <= s2_brake_ff;
         rsp_last_frame      <= s2_left_ff;
      end
   end

   // A right frame that leaves is always followed at once by its left frame.
   `DIES_ASSERT_NEXT(a_left_follows_right, clock, reset,
      rsp_valid && !rsp_stall && !rsp_last_frame, rsp_valid && rsp_last_frame,
      "right command frame not followed by left frame")

   // Torque is only ever commanded in the running state.
   `DIES_ASSERT_SAME(a_torque_only_running, clock, reset,
      rsp_valid && (rsp_torque_setpoint != '0), rsp_control_state == CS_RUNNING,
      "nonzero torque outside running state")

   // The brake light never turns off once on.
   `DIES_ASSERT_NEXT(a_brake_sticky, clock, reset,
      brake_on_ff, brake_on_ff,
      "brake light cleared after being set")

   // The quotient estimate needs no more than one correction.
   `DIES_ASSERT_SAME(a_div_one_step, clock, reset,
      s2_valid_ff, rem_full < (PROD_W+1)'(2 * SAMPLE_FULL),
      "divider remainder out of range")

endmodule

`default_nettype wire
